// ===== rtl/core/mprv_pkg.sv =====
// ----------------------------------------------------------------------------
// mprv_pkg
// Types, constants and SHA-256 helpers for the Merkle proof root verifier.
// ----------------------------------------------------------------------------
package mprv_pkg;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_ROOT   = 2'd1,
		OP_SIB    = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned TALLY_W  = 7;
	localparam logic [TALLY_W-1:0] TALLY_MAX = 7'd127;

	typedef logic [3:0][WORD_W-1:0] hash_t;

	typedef struct packed {
		op_t         op;
		hash_t       words;
		logic [63:0] position;
		logic [63:0] total;
	} req_t;

	typedef struct packed {
		hash_t root;
		logic  well_formed;
		logic  root_equal;
	} rsp_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0][31:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/core/mprv_stream_if.sv =====
// ----------------------------------------------------------------------------
// mprv_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface mprv_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mprv_front.sv =====
// ----------------------------------------------------------------------------
// mprv_front
// Accept requests and hold them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mprv_front (
	input  logic          clk,
	input  logic          arst_n,
	mprv_stream_if.sink   req,
	input  logic          pop,
	output logic          avail,
	output mprv_pkg::req_t head
);
	import mprv_pkg::*;

	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign avail     = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/core/mprv_sha_core.sv =====
// ----------------------------------------------------------------------------
// mprv_sha_core
// SHA-256 over one 64-byte block and its padding block, one round a cycle.
// ----------------------------------------------------------------------------
module mprv_sha_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [15:0][31:0] blk,
	output logic           done,
	output mprv_pkg::hash_t digest
);
	import mprv_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FOLD} state_t;

	state_t           state_q;
	logic             second_q;
	logic [5:0]       rnd_q;
	logic [15:0][31:0] w_q;
	logic [7:0][31:0] st_q;
	logic [7:0][31:0] v_q;
	logic [31:0]      wn, t1, t2, s0, s1, a, b, c, e, f, g, h;
	logic [7:0][31:0] sum;
	logic [15:0][31:0] pad;

	always_comb begin
		pad = '0;
		pad[15] = 32'h80000000;
		pad[0]  = 32'd512;
		s0 = rotr(w_q[14], 7) ^ rotr(w_q[14], 18) ^ (w_q[14] >> 3);
		s1 = rotr(w_q[1], 17) ^ rotr(w_q[1], 19) ^ (w_q[1] >> 10);
		wn = w_q[15] + s0 + w_q[6] + s1;
		a = v_q[7]; b = v_q[6]; c = v_q[5];
		e = v_q[3]; f = v_q[2]; g = v_q[1]; h = v_q[0];
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ ROUND_K[rnd_q] + w_q[15];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		for (int i = 0; i < 8; i++) sum[i] = st_q[i] + v_q[i];
		for (int i = 0; i < 4; i++) digest[i] = {st_q[7-2*i], st_q[6-2*i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
			rnd_q    <= '0;
			done     <= 1'b0;
		end else begin
			done <= (state_q == S_FOLD) && second_q;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_RUN;
						second_q <= 1'b0;
						rnd_q    <= '0;
					end
				end
				S_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (second_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q  <= S_RUN;
						second_q <= 1'b1;
						rnd_q    <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					for (int i = 0; i < 16; i++) w_q[15-i] <= blk[i];
					st_q <= INIT_H;
					v_q  <= INIT_H;
				end
			end
			S_RUN: begin
				w_q <= {w_q[14:0], wn};
				v_q <= {t1 + t2, v_q[7:5], v_q[4] + t1, v_q[3:1]};
			end
			S_FOLD: begin
				st_q <= sum;
				v_q  <= sum;
				w_q  <= pad;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/mprv_back.sv =====
// ----------------------------------------------------------------------------
// mprv_back
// Execute queued requests: load state, hash siblings, report on finish.
// ----------------------------------------------------------------------------
module mprv_back #(
	parameter int unsigned MAX_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  mprv_pkg::req_t head,
	output logic          pop,
	mprv_stream_if.source rsp
);
	import mprv_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_HASH, B_WAIT} state_t;

	state_t         state_q;
	hash_t          run_q, exp_q;
	logic [63:0]    pos_q, total_q;
	logic [TALLY_W-1:0] tally_q;
	logic           hstart;
	logic           hdone;
	logic           fin_go;
	hash_t          digest;
	logic [15:0][31:0] blk;
	hash_t          lft, rgt;
	logic [6:0]     depth;
	logic [63:0]    nm1;
	logic           shape_ok;
	rsp_t           rsp_d;

	always_comb begin
		lft = pos_q[0] ? head.words : run_q;
		rgt = pos_q[0] ? run_q : head.words;
		for (int i = 0; i < 4; i++) begin
			blk[2*i]     = lft[i][63:32];
			blk[2*i+1]   = lft[i][31:0];
			blk[8+2*i]   = rgt[i][63:32];
			blk[8+2*i+1] = rgt[i][31:0];
		end
		nm1   = total_q - 64'd1;
		depth = '0;
		for (int i = 0; i < 64; i++) if (nm1[i]) depth = 7'(i + 1);
		if (total_q <= 64'd1) depth = '0;
		shape_ok = (total_q != '0) && (depth <= 7'(MAX_DEPTH)) && (tally_q == depth);
		rsp_d.root        = run_q;
		rsp_d.well_formed = shape_ok;
		rsp_d.root_equal  = shape_ok && (run_q == exp_q);
	end

	assign hstart = (state_q == B_IDLE) && avail && (head.op == OP_SIB);
	assign fin_go = (state_q == B_IDLE) && avail && (head.op == OP_FINISH)
		&& (!rsp.valid || rsp.ready);
	assign pop = ((state_q == B_IDLE) && avail &&
		(head.op == OP_START || head.op == OP_ROOT))
		|| fin_go
		|| ((state_q == B_HASH) && hdone);

	mprv_sha_core u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hstart),
		.blk    (blk),
		.done   (hdone),
		.digest (digest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			run_q       <= '0;
			exp_q       <= '0;
			pos_q       <= '0;
			total_q     <= '0;
			tally_q     <= '0;
			rsp.valid   <= 1'b0;
			rsp.payload <= '0;
		end else begin
			if (fin_go) begin
				rsp.valid   <= 1'b1;
				rsp.payload <= rsp_d;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (avail) begin
						case (head.op)
							OP_START: begin
								run_q   <= head.words;
								pos_q   <= head.position;
								total_q <= (head.position < head.total) ? head.total : '0;
								tally_q <= '0;
							end
							OP_ROOT: exp_q <= head.words;
							OP_SIB: state_q <= B_HASH;
							default: ;
						endcase
					end
				end
				B_HASH: begin
					if (hdone) begin
						run_q   <= digest;
						pos_q   <= pos_q >> 1;
						if (tally_q != TALLY_MAX) tally_q <= tally_q + 7'd1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/merkle_proof_root_verifier.sv =====
// ----------------------------------------------------------------------------
// merkle_proof_root_verifier
// Merkle inclusion proof check with SHA-256 over sibling pairs.
// Sibling requests run two compressions of 64 rounds each on the shared round
// unit, each followed by a fold step, between an issue step and a retire step.
// Other requests retire from the idle state; a finish waits for a free response slot.
// A finish result is registered and presented in the cycle after the request leaves the queue.
// Asynchronous reset clears all proof state, including the stored hashes.
// ----------------------------------------------------------------------------
module merkle_proof_root_verifier #(
	parameter int unsigned MAX_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	mprv_stream_if.sink   req,
	mprv_stream_if.source rsp
);
	import mprv_pkg::*;

	logic pop, avail;
	req_t head;

	mprv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.avail  (avail),
		.head   (head)
	);

	mprv_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Merkle proof root verifier. Drives directed and
// random proofs (correct, corrupted and malformed) plus random noise requests,
// predicts each finish result with a local SHA-256 model and checks every
// response field by field, under random stalls on both sides for the first two thirds of items.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mprv_pkg::*;

	localparam int ITEMS    = 750;
	localparam int WD_LIMIT = 6000;
	localparam int DEPTH    = 64;

	class proof_scoreboard;
		hash_t       running;
		hash_t       exp_root;
		logic [63:0] shifted_pos;
		logic [63:0] stored_total;
		logic [6:0]  tally;
		rsp_t        pending_results[$];
		int          errors;

		function new();
			running       = '0;
			exp_root      = '0;
			shifted_pos   = '0;
			stored_total  = '0;
			tally         = '0;
			errors        = 0;
		endfunction

		static function logic [31:0] ror(logic [31:0] x, int n);
			logic [63:0] d;
			d = {x, x} >> n;
			return d[31:0];
		endfunction

		static function void compress(ref logic [31:0] st[8], input logic [31:0] blk[16]);
			logic [31:0] w[64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
			for (int i = 0; i < 16; i++) w[i] = blk[i];
			for (int i = 16; i < 64; i++)
				w[i] = w[i-16] + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
			a = st[0]; b = st[1]; c = st[2]; d = st[3];
			e = st[4]; f = st[5]; g = st[6]; h = st[7];
			for (int i = 0; i < 64; i++) begin
				t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ ROUND_K[i] + w[i];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			st[0] += a; st[1] += b; st[2] += c; st[3] += d;
			st[4] += e; st[5] += f; st[6] += g; st[7] += h;
		endfunction

		static function hash_t pair_hash(hash_t left, hash_t right);
			logic [31:0] st[8];
			logic [31:0] blk[16];
			hash_t       res;
			for (int i = 0; i < 8; i++) st[i] = INIT_H[7-i];
			for (int i = 0; i < 4; i++) begin
				blk[2*i]       = left[i][63:32];
				blk[2*i+1]     = left[i][31:0];
				blk[8+2*i]     = right[i][63:32];
				blk[8+2*i+1]   = right[i][31:0];
			end
			compress(st, blk);
			for (int i = 0; i < 16; i++) blk[i] = '0;
			blk[0]  = 32'h8000_0000;
			blk[15] = 32'd512;
			compress(st, blk);
			for (int i = 0; i < 4; i++) res[i] = {st[2*i], st[2*i+1]};
			return res;
		endfunction

		static function int tree_depth(logic [63:0] count);
			logic [63:0] n;
			int          d;
			d = 0;
			if (count <= 1) return 0;
			n = count - 1;
			while (n != 0) begin
				n >>= 1;
				d++;
			end
			return d;
		endfunction

		function void note_request(req_t r);
			rsp_t res;
			int   dep;
			case (r.op)
				OP_START: begin
					running      = r.words;
					shifted_pos  = r.position;
					stored_total = (r.position < r.total) ? r.total : '0;
					tally        = '0;
				end
				OP_ROOT: exp_root = r.words;
				OP_SIB: begin
					running     = shifted_pos[0] ? pair_hash(r.words, running)
						: pair_hash(running, r.words);
					shifted_pos = shifted_pos >> 1;
					if (tally != TALLY_MAX) tally++;
				end
				OP_FINISH: begin
					dep             = tree_depth(stored_total);
					res.root        = running;
					res.well_formed = stored_total != 0 && dep <= DEPTH && int'(tally) == dep;
					res.root_equal  = res.well_formed && running == exp_root;
					pending_results.insert(pending_results.size(), res);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response root_word_0", got.root[0], '0);
				return;
			end
			want = pending_results.pop_front();
			for (int i = 0; i < 4; i++)
				if (got.root[i] !== want.root[i])
					report_mismatch($sformatf("root_word_%0d", i), got.root[i], want.root[i]);
			if (got.well_formed !== want.well_formed)
				report_mismatch("proof_well_formed", got.well_formed, want.well_formed);
			if (got.root_equal !== want.root_equal)
				report_mismatch("root_matches", got.root_equal, want.root_equal);
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   src_idle, snk_idle, sent, quiet_cycles;
	proof_scoreboard sb;

	mprv_stream_if #(.payload_t(req_t)) req_if ();
	mprv_stream_if #(.payload_t(rsp_t)) rsp_if ();

	merkle_proof_root_verifier #(.MAX_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	always @(negedge clk) rsp_if.ready <= ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WD_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic hash_t rand_hash();
		hash_t h;
		for (int i = 0; i < 4; i++) h[i] = {$urandom, $urandom};
		return h;
	endfunction

	task automatic send(op_t op, hash_t words, logic [63:0] pos = '0, logic [63:0] total = '0);
		req_t r;
		r.op = op; r.words = words; r.position = pos; r.total = total;
		if (sent < ITEMS / 3) begin
			src_idle = 27; snk_idle = 71;
		end else if (sent < 2 * ITEMS / 3) begin
			src_idle = 71; snk_idle = 27;
		end else begin
			src_idle = 0; snk_idle = 0;
		end
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(r);
		sent++;
	endtask

	// walk one proof; sib_delta adds or removes siblings, bad_root corrupts the root
	task automatic run_proof(logic [63:0] count, logic [63:0] idx, bit bad_root,
		int sib_delta, bit root_first);
		hash_t       leaf, acc, root_val;
		hash_t       sibs[$];
		logic [63:0] p;
		int          n;
		leaf = rand_hash();
		acc  = leaf;
		p    = idx;
		n    = proof_scoreboard::tree_depth(count) + sib_delta;
		if (n < 0) n = 0;
		for (int i = 0; i < n; i++) begin
			sibs.insert(sibs.size(), rand_hash());
			acc = p[0] ? proof_scoreboard::pair_hash(sibs[i], acc)
				: proof_scoreboard::pair_hash(acc, sibs[i]);
			p >>= 1;
		end
		root_val = acc;
		if (bad_root) root_val[$urandom_range(3)][$urandom_range(63)] ^= 1'b1;
		if (root_first) send(OP_ROOT, root_val);
		send(OP_START, leaf, idx, count);
		if (!root_first) send(OP_ROOT, root_val);
		foreach (sibs[i]) send(OP_SIB, sibs[i]);
		send(OP_FINISH, rand_hash(), {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	initial begin
		logic [63:0] cnt, idx;
		int          pick;
		sb             = new();
		sent           = 0;
		quiet_cycles   = 0;
		src_idle       = 27;
		snk_idle       = 71;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		arst_n         = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(OP_FINISH, '0);
		send(OP_SIB, '1);
		send(OP_FINISH, '1, '1, '1);
		send(OP_START, '1, '0, 64'd1);
		send(OP_ROOT, '1);
		send(OP_FINISH, '0);
		send(OP_START, rand_hash(), '1, '1);
		send(OP_FINISH, '0);
		send(OP_START, rand_hash(), '0, '0);
		send(OP_FINISH, '0);
		run_proof(64'd2, 64'd1, 1'b0, 0, 1'b0);
		run_proof(64'd5, 64'd4, 1'b0, 0, 1'b1);
		run_proof(64'd4, 64'd2, 1'b1, 0, 1'b0);
		run_proof(64'd3, 64'd0, 1'b0, 1, 1'b0);

		run_proof('1, '1 - 64'd1, 1'b0, 0, 1'b0);
		run_proof(64'd2, 64'd0, 1'b0, 127, 1'b0);

		while (sent < ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				if ($urandom_range(9) < 8) begin
					cnt = $urandom_range(1, 40);
					idx = $urandom_range(0, cnt - 1);
				end else begin
					cnt = {$urandom, $urandom} >> $urandom_range(63);
					if (cnt == 0) cnt = 1;
					idx = {$urandom, $urandom} % cnt;
				end
				run_proof(cnt, idx, $urandom_range(4) == 0,
					($urandom_range(6) == 0) ? ($urandom_range(1) ? 1 : -1) : 0,
					$urandom_range(1));
			end else if (pick < 88) begin
				send(op_t'($urandom_range(3)), rand_hash(), {$urandom, $urandom},
					{$urandom, $urandom});
			end else begin
				cnt = $urandom_range(0, 20);
				run_proof(cnt, cnt + $urandom_range(0, 3), 1'b0, 0, $urandom_range(1));
			end
		end
		@(negedge clk);
		req_if.valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ===== merkle_proof_root_verifier.f =====
rtl/core/mprv_pkg.sv
rtl/core/mprv_stream_if.sv
rtl/core/mprv_front.sv
rtl/core/mprv_sha_core.sv
rtl/core/mprv_back.sv
rtl/core/merkle_proof_root_verifier.sv
bench/tb_top.sv
